/* design/density_minhash_signature_top_defines.svh */
// Assertion macros used by the top-level design file
`ifndef DENSITY_MINHASH_SIGNATURE_TOP_DEFINES_SVH
`define DENSITY_MINHASH_SIGNATURE_TOP_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define DMS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define DMS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dms_pkg.sv */
package dms_pkg;

    localparam int FeatureRows     = 64;
    localparam int SignatureLength = 32;
    localparam int RowW  = 6;
    localparam int SlotW = 5;
    localparam int PermDepth = SignatureLength * FeatureRows;
    localparam int PermAddrW = SlotW + RowW;

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_PERM     = 2'd1;
    localparam logic [1:0] CMD_COMPUTE  = 2'd2;
    // Unassigned code, accepted and dropped
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RANK,
        ST_MARK,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

/* design/dms_ram.sv */
module dms_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/density_minhash_signature_top.sv */
// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | command, row, sample, perm fields
// m_       | out       | m_valid / m_ready  | signature_slot, value, last_item
// cfg_     | in        | cfg_we, no ready   | threshold_rank
// Add: sum read, then saturating write; permutation write or unused code: handled on acceptance.
// Compute: 64 rank passes, one mark pass, then per slot a scan and an output that waits
//   for m_ready; a clear of the sums follows.
// Sequencing is set by one shared 32-bit compare unit and one port of each memory.
// Reset (synchronous, aresetn low) clears the row sums in one pass; s_ready stays low.
// A stalled m_ready holds the result and the sequencer.
`include "density_minhash_signature_top_defines.svh"
module density_minhash_signature_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [5:0]  s_row_index,
    input  logic signed [15:0] s_sample_value,
    input  logic [4:0]  s_perm_select,
    input  logic [5:0]  s_perm_position,
    input  logic [5:0]  s_perm_entry,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_signature_slot,
    output logic [5:0]  m_signature_value,
    output logic        m_last_item
);
    localparam int RW = dms_pkg::RowW;
    localparam int SW = dms_pkg::SlotW;

    dms_pkg::state_t state_reg, state_next;
    logic [5:0]  rank_reg;
    logic [RW:0] i_reg, i_next;      // outer index, extra bit for done
    logic [RW:0] j_reg, j_next;
    logic [SW:0] k_reg, k_next;
    logic [RW:0] cnt_reg, cnt_next;
    logic        ph_reg, ph_next;    // phase inside a step
    logic signed [31:0] v_reg, v_next, best_reg, best_next;
    logic        found_reg, found_next;
    logic [dms_pkg::FeatureRows-1:0] marked_reg, marked_next;
    logic        hit_reg, hit_next;
    logic [RW-1:0] val_reg, val_next;
    logic        mv_reg, mv_next;
    logic        add_reg, add_next;   // pending add write
    logic [RW-1:0] arow_reg, arow_next;
    logic signed [15:0] asamp_reg, asamp_next;

    // Row sum memory
    logic          sum_we;
    logic [RW-1:0] sum_waddr, sum_raddr;
    logic signed [31:0] sum_wdata, sum_rdata;
    dms_ram #(.Width(32), .Depth(dms_pkg::FeatureRows)) u_sum (
        .aclk(aclk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
        .raddr(sum_raddr), .rdata(sum_rdata)
    );

    // Permutation memory
    logic perm_we;
    logic [dms_pkg::PermAddrW-1:0] perm_raddr;
    logic [RW-1:0] perm_rdata;
    dms_ram #(.Width(RW), .Depth(dms_pkg::PermDepth)) u_perm (
        .aclk(aclk), .we(perm_we), .waddr({s_perm_select, s_perm_position}),
        .wdata(s_perm_entry), .raddr(perm_raddr), .rdata(perm_rdata)
    );

    logic s_acc;
    assign s_acc = s_valid && s_ready;
    assign s_ready = (state_reg == dms_pkg::ST_IDLE) && !add_reg;
    assign perm_we = s_acc && (s_command == dms_pkg::CMD_PERM);

    // Shared compare unit
    logic signed [31:0] cmp_a, cmp_b;
    logic cmp_le;
    assign cmp_le = cmp_a <= cmp_b;

    // Saturating add
    logic signed [32:0] add_sum;
    logic signed [31:0] add_sat;
    assign add_sum = 33'(sum_rdata) + 33'(asamp_reg);
    always_comb begin
        if (add_sum > 33'sh0_7FFF_FFFF) add_sat = 32'sh7FFF_FFFF;
        else if (add_sum < -33'sh0_8000_0000) add_sat = 32'sh8000_0000;
        else add_sat = add_sum[31:0];
    end

    // Threshold rank register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= '0;
        end else if (cfg_we) begin
            rank_reg <= cfg_wdata;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dms_pkg::ST_IDLE: begin
                if (s_acc && s_command == dms_pkg::CMD_COMPUTE) state_next = dms_pkg::ST_RANK;
            end
            dms_pkg::ST_CLEAR: if (i_reg[RW]) state_next = dms_pkg::ST_IDLE;
            dms_pkg::ST_RANK:  if (i_reg[RW]) state_next = dms_pkg::ST_MARK;
            dms_pkg::ST_MARK:  if (i_reg[RW] && ph_reg) state_next = dms_pkg::ST_SCAN;
            dms_pkg::ST_SCAN: begin
                if (hit_reg || j_reg[RW]) state_next = dms_pkg::ST_OUT;
            end
            dms_pkg::ST_OUT: begin
                if (m_ready) begin
                    if (k_reg == (SW+1)'(dms_pkg::SignatureLength - 1))
                        state_next = dms_pkg::ST_CLEAR;
                    else state_next = dms_pkg::ST_SCAN;
                end
            end
            default: state_next = dms_pkg::ST_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        i_next = i_reg; j_next = j_reg; k_next = k_reg; cnt_next = cnt_reg;
        ph_next = ph_reg; v_next = v_reg; best_next = best_reg; found_next = found_reg;
        marked_next = marked_reg; hit_next = hit_reg; val_next = val_reg;
        mv_next = mv_reg; add_next = 1'b0; arow_next = arow_reg; asamp_next = asamp_reg;
        sum_we = 1'b0; sum_waddr = arow_reg; sum_wdata = add_sat;
        sum_raddr = s_row_index;
        perm_raddr = {k_reg[SW-1:0], j_reg[RW-1:0]};
        cmp_a = v_reg; cmp_b = best_reg;
        if (m_valid && m_ready) mv_next = 1'b0;
        // Finish pending add
        if (add_reg) begin
            sum_we = 1'b1;
        end
        case (state_reg)
            dms_pkg::ST_IDLE: begin
                if (s_acc && s_command == dms_pkg::CMD_ADD) begin
                    add_next = 1'b1; arow_next = s_row_index; asamp_next = s_sample_value;
                end
                if (s_acc && s_command == dms_pkg::CMD_COMPUTE) begin
                    i_next = '0; j_next = '0; ph_next = 1'b0; found_next = 1'b0;
                    best_next = 32'sh7FFF_FFFF; cnt_next = '0;
                end
            end
            dms_pkg::ST_CLEAR: begin
                sum_we = 1'b1; sum_waddr = i_reg[RW-1:0]; sum_wdata = '0;
                i_next = i_reg + 1'b1;
            end
            dms_pkg::ST_RANK: begin
                // ph 0: read row i as candidate; then walk j reading row j
                if (!ph_reg) begin
                    sum_raddr = i_reg[RW-1:0];
                    ph_next = 1'b1; j_next = '0; cnt_next = '0;
                end else if (j_reg == '0) begin
                    // Latch the candidate and issue the first row read
                    sum_raddr = j_reg[RW-1:0];
                    v_next = sum_rdata;
                    j_next = j_reg + 1'b1;
                end else if (j_reg <= (RW+1)'(dms_pkg::FeatureRows)) begin
                    // Issue read j, count row j-1, whose read was issued in the previous cycle
                    sum_raddr = j_reg[RW-1:0];
                    cmp_a = sum_rdata; cmp_b = v_reg;
                    if (cmp_le) cnt_next = cnt_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                end else begin
                    // Keep the candidate when enough rows sit at or below it and it is smaller
                    cmp_a = best_reg; cmp_b = v_reg;
                    if (cnt_reg > {1'b0, rank_reg} && (!found_reg || !cmp_le)) begin
                        best_next = v_reg; found_next = 1'b1;
                    end
                    ph_next = 1'b0; i_next = i_reg + 1'b1; j_next = '0;
                end
                if (i_next[RW]) begin
                    i_next = '0; ph_next = 1'b0;
                    if (state_reg == dms_pkg::ST_RANK) i_next = {1'b1, {RW{1'b0}}};
                end
            end
            dms_pkg::ST_MARK: begin
                if (i_reg[RW] && !ph_reg) begin
                    i_next = '0; ph_next = 1'b0;
                end
                sum_raddr = i_reg[RW-1:0];
                if (!ph_reg) begin
                    ph_next = 1'b1; i_next = i_reg;
                    if (i_reg[RW]) i_next = '0;
                end else if (!i_reg[RW]) begin
                    cmp_a = sum_rdata; cmp_b = best_reg;
                    marked_next[i_reg[RW-1:0]] = !cmp_le;
                    if (i_reg == (RW+1)'(dms_pkg::FeatureRows - 1)) begin
                        i_next = {1'b1, {RW{1'b0}}};
                        k_next = '0; j_next = '0; hit_next = 1'b0; ph_next = 1'b1;
                    end else begin
                        i_next = i_reg + 1'b1;
                        sum_raddr = i_next[RW-1:0];
                    end
                end
            end
            dms_pkg::ST_SCAN: begin
                // Read issued at j; check data from j-1 (ph marks data ready)
                if (!hit_reg && !j_reg[RW]) begin
                    perm_raddr = {k_reg[SW-1:0], j_reg[RW-1:0]};
                    j_next = j_reg + 1'b1;
                end
                if (ph_reg && j_reg != '0) begin
                    if (marked_reg[perm_rdata] && !hit_reg) begin
                        hit_next = 1'b1; val_next = RW'(j_reg - 1'b1);
                        j_next = j_reg;
                    end
                end
                if (j_reg == '0) ph_next = 1'b1;
                if (j_reg[RW] && !hit_reg && !(marked_reg[perm_rdata])) val_next = '0;
                if (state_next == dms_pkg::ST_OUT) begin
                    mv_next = 1'b1;
                    if (!hit_reg && !(j_reg[RW] && marked_reg[perm_rdata])) val_next = '0;
                    if (j_reg[RW] && !hit_reg && marked_reg[perm_rdata])
                        val_next = RW'(j_reg - 1'b1);
                    if (hit_reg) val_next = val_reg;
                end
            end
            dms_pkg::ST_OUT: begin
                if (m_ready) begin
                    k_next = k_reg + 1'b1; j_next = '0; hit_next = 1'b0; ph_next = 1'b1;
                    i_next = '0;
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dms_pkg::ST_CLEAR;
            i_reg <= '0; mv_reg <= 1'b0; add_reg <= 1'b0; marked_reg <= '0;
            ph_reg <= 1'b0; found_reg <= 1'b0; hit_reg <= 1'b0;
            j_reg <= '0; k_reg <= '0; cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; cnt_reg <= cnt_next;
            ph_reg <= ph_next; found_reg <= found_next; marked_reg <= marked_next;
            hit_reg <= hit_next; mv_reg <= mv_next; add_reg <= add_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next; best_reg <= best_next; val_reg <= val_next;
        arow_reg <= arow_next; asamp_reg <= asamp_next;
    end

    assign m_valid = mv_reg;
    assign m_signature_slot = k_reg[SW-1:0];
    assign m_signature_value = val_reg;
    assign m_last_item = (k_reg == (SW+1)'(dms_pkg::SignatureLength - 1));

    `DMS_ASSERT_IMPLY(a_busy_out, aclk, aresetn, m_valid, !s_ready, "result while ready")
    `DMS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    `DMS_ASSERT_IMPLY(a_out_state, aclk, aresetn, m_valid, state_reg == dms_pkg::ST_OUT, "valid outside output")
endmodule
